// ===== hw/rtl/bfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants for the breadth-first shortest path core.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int VTX_DEFAULT = 64;
    localparam int VTX_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam logic [CNT_BITS-1:0] COUNT_RESET = 7'd64;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_FETCH,
        ST_ROW,
        ST_SCAN,
        ST_CHECK,
        ST_TRACE,
        ST_EMIT,
        ST_FAIL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic seed;
        logic pop;
        logic fetch;
        logic row_load;
        logic scan_step;
        logic trace_start;
        logic trace_step;
        logic emit_start;
        logic emit_step;
        logic out_load_fail;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic range_bad;
        logic queue_empty;
        logic scan_done;
        logic target_seen;
        logic trace_done;
        logic emit_done;
        logic out_pend;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer for clearing, search, path trace and path emission.
// ----------------------------------------------------------------------------
module bfs_ctrl
    import bfs_pkg::*;
(
    input  wire    clk,
    input  wire    rst_n,
    input  wire    start_search,
    input  wire    out_free,
    input  stat_t  stat,
    output cmd_t   cmd,
    output logic   busy
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_search)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:
            begin
                state_next = stat.range_bad ? ST_FAIL : ST_POP;
            end
            ST_POP:
            begin
                state_next = stat.queue_empty ? ST_CHECK : ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_POP;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.target_seen ? ST_TRACE : ST_FAIL;
            end
            ST_TRACE:
            begin
                if (stat.trace_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && !stat.out_pend && stat.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_SEED:  cmd.seed = 1'b1;
            ST_POP:   cmd.pop = !stat.queue_empty;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_ROW:   cmd.row_load = 1'b1;
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_CHECK: cmd.trace_start = stat.target_seen;
            ST_TRACE:
            begin
                cmd.trace_step = 1'b1;
                cmd.emit_start = stat.trace_done;
            end
            ST_EMIT:  cmd.emit_step = out_free && !stat.out_pend;
            ST_FAIL:  cmd.out_load_fail = out_free;
            default:  busy = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bfs_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_dpath
// Adjacency memory, search tables, queue, path buffer and output register.
// ----------------------------------------------------------------------------
module bfs_dpath
    import bfs_pkg::*;
#(
    parameter int MAX_VERTICES = VTX_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  wire                 wr_edge,
    input  wire [VTX_BITS-1:0]  in_a,
    input  wire [VTX_BITS-1:0]  in_b,
    input  wire                 in_bit,
    input  wire                 start_search,
    input  wire                 cfg_we,
    input  wire [CNT_BITS-1:0]  cfg_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [VTX_BITS-1:0] out_vertex,
    output logic                out_reach,
    output logic [VTX_BITS-1:0] out_hops,
    output logic                out_last
);

    localparam int LIM   = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int AW    = $clog2(LIM);
    localparam logic [CNT_BITS-1:0] LIM_C = CNT_BITS'(LIM);

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] n_eff;
    logic [VTX_BITS-1:0] src_reg, dst_reg;
    logic [LIM-1:0]      visited_reg;
    logic [CNT_BITS-1:0] head_reg, tail_reg;
    logic [AW-1:0]       clr_reg;
    logic [VTX_BITS-1:0] u_reg;
    logic [VTX_BITS-1:0] du_reg;
    logic [LIM-1:0]      row_reg;
    logic [CNT_BITS-1:0] v_reg;
    logic [VTX_BITS-1:0] cur_reg;
    logic [CNT_BITS-1:0] len_reg;
    logic [CNT_BITS-1:0] k_reg;
    logic                trace_wait_reg;
    logic [VTX_BITS-1:0] hops_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        n_eff = count_reg;
        if (count_reg == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        if (count_reg > LIM_C)
        begin
            n_eff = LIM_C;
        end
    end

    // adjacency memory, written by edge beats and the clearing pass
    logic          adj_we;
    logic [AW-1:0] adj_waddr, adj_raddr;
    logic [LIM-1:0] adj_wdata, adj_rdata, adj_row_mux;
    logic          edge_ok;

    assign edge_ok = (CNT_BITS'(in_a) < LIM_C) && (CNT_BITS'(in_b) < LIM_C);
    assign adj_row_mux = adj_rdata;

    // edge writes are read-modify-write of the row read in the accept cycle
    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = in_a[AW-1:0];
        adj_wdata = adj_rdata;
        if (cmd.clear_step)
        begin
            adj_we    = 1'b1;
            adj_waddr = clr_reg;
            adj_wdata = '0;
        end
        else if (wr_edge && edge_ok)
        begin
            adj_we = 1'b1;
            adj_wdata = adj_rdata;
            adj_wdata[in_b[AW-1:0]] = in_bit;
        end
    end

    bfs_ram #(.WIDTH(LIM), .DEPTH(LIM)) u_adj (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // search tables
    logic                dist_we, par_we, q_we, pb_we;
    logic [AW-1:0]       dist_wa, par_wa, q_wa, pb_wa;
    logic [VTX_BITS-1:0] dist_wd, par_wd, q_wd, pb_wd;
    logic [AW-1:0]       dist_ra, par_ra, q_ra, pb_ra;
    logic [VTX_BITS-1:0] dist_rd, par_rd, q_rd, pb_rd;

    bfs_ram #(.WIDTH(VTX_BITS), .DEPTH(LIM)) u_dist (
        .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
        .raddr(dist_ra), .rdata(dist_rd));
    bfs_ram #(.WIDTH(VTX_BITS), .DEPTH(LIM)) u_par (
        .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
        .raddr(par_ra), .rdata(par_rd));
    bfs_ram #(.WIDTH(VTX_BITS), .DEPTH(LIM)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
        .raddr(q_ra), .rdata(q_rd));
    bfs_ram #(.WIDTH(VTX_BITS), .DEPTH(LIM)) u_path (
        .clk(clk), .we(pb_we), .waddr(pb_wa), .wdata(pb_wd),
        .raddr(pb_ra), .rdata(pb_rd));

    logic new_nbr;
    logic [AW-1:0] v_idx;
    assign v_idx   = v_reg[AW-1:0];
    assign new_nbr = cmd.scan_step && row_reg[v_idx] && !visited_reg[v_idx];

    // table write and read address selection
    always_comb
    begin
        dist_we = 1'b0;
        dist_wa = v_idx;
        dist_wd = du_reg + VTX_BITS'(1);
        par_we  = 1'b0;
        par_wa  = v_idx;
        par_wd  = u_reg;
        q_we    = 1'b0;
        q_wa    = tail_reg[AW-1:0];
        q_wd    = VTX_BITS'(v_reg);
        if (cmd.seed)
        begin
            dist_we = 1'b1;
            dist_wa = src_reg[AW-1:0];
            dist_wd = '0;
            par_we  = 1'b1;
            par_wa  = src_reg[AW-1:0];
            par_wd  = src_reg;
            q_we    = 1'b1;
            q_wa    = '0;
            q_wd    = src_reg;
        end
        else if (new_nbr)
        begin
            dist_we = 1'b1;
            par_we  = 1'b1;
            q_we    = (tail_reg < LIM_C);
        end
    end

    assign q_ra    = head_reg[AW-1:0];
    assign dist_ra = cmd.fetch ? q_rd[AW-1:0] : dst_reg[AW-1:0];
    assign par_ra  = cur_reg[AW-1:0];
    assign pb_we   = cmd.trace_step && !trace_wait_reg && !stat.trace_done;
    assign pb_wa   = len_reg[AW-1:0];
    assign pb_wd   = cur_reg;
    assign pb_ra   = (len_reg - CNT_BITS'(1) - k_reg) >= CNT_BITS'(LIM) ? '0
                   : AW'(len_reg - CNT_BITS'(1) - k_reg);

    // adjacency read port: row of the vertex being expanded, or edge row
    always_comb
    begin
        adj_raddr = in_a[AW-1:0];
        if (cmd.fetch)
        begin
            adj_raddr = q_rd[AW-1:0];
        end
    end

    // queue pop pipeline: head read in pop, vertex known in fetch
    logic [VTX_BITS-1:0] u_pend_reg;

    // search control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            v_reg          <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            trace_wait_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.seed)
            begin
                visited_reg <= LIM'(1) << src_reg[AW-1:0];
                head_reg <= '0;
                tail_reg <= CNT_BITS'(1);
            end
            if (cmd.pop)
            begin
                head_reg <= head_reg + CNT_BITS'(1);
            end
            if (cmd.row_load)
            begin
                v_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                v_reg <= v_reg + CNT_BITS'(1);
                if (new_nbr)
                begin
                    visited_reg[v_idx] <= 1'b1;
                    if (tail_reg < LIM_C)
                    begin
                        tail_reg <= tail_reg + CNT_BITS'(1);
                    end
                end
            end
            if (cmd.trace_start)
            begin
                len_reg        <= '0;
                trace_wait_reg <= 1'b0;
            end
            if (cmd.trace_step && !stat.trace_done)
            begin
                if (trace_wait_reg)
                begin
                    trace_wait_reg <= 1'b0;
                end
                else
                begin
                    len_reg        <= len_reg + CNT_BITS'(1);
                    trace_wait_reg <= 1'b1;
                end
            end
            if (cmd.emit_start)
            begin
                k_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                k_reg <= k_reg + CNT_BITS'(1);
            end
        end
    end

    // payload registers of the search
    always_ff @(posedge clk)
    begin
        if (start_search)
        begin
            src_reg <= in_a;
            dst_reg <= in_b;
        end
        if (cmd.row_load)
        begin
            row_reg <= adj_row_mux;
        end
        if (cmd.fetch)
        begin
            u_pend_reg <= q_rd;
        end
        if (cmd.row_load)
        begin
            u_reg  <= u_pend_reg;
            du_reg <= dist_rd;
        end
        if (cmd.trace_start)
        begin
            cur_reg  <= dst_reg;
            hops_reg <= dist_rd;
        end
        else if (cmd.trace_step && trace_wait_reg)
        begin
            cur_reg <= par_rd;
        end
    end

    logic pb_wd_prev_src;
    logic last_src_reg;
    logic emit_pend_reg, emit_last_reg;

    // status back to the controller
    logic q_empty;
    assign q_empty = !(head_reg < tail_reg) || !(head_reg < LIM_C);

    always_comb
    begin
        stat             = '0;
        stat.clear_done  = (clr_reg == AW'(LIM - 1));
        stat.range_bad   = (CNT_BITS'(src_reg) >= n_eff) || (CNT_BITS'(dst_reg) >= n_eff);
        stat.queue_empty = q_empty;
        stat.scan_done   = (v_reg + CNT_BITS'(1) >= n_eff);
        stat.target_seen = visited_reg[dst_reg[AW-1:0]];
        stat.trace_done  = !trace_wait_reg && (len_reg != '0)
                         && ((pb_wd_prev_src) || (len_reg >= n_eff));
        stat.emit_done   = (k_reg + CNT_BITS'(1) == len_reg);
        stat.out_pend    = emit_pend_reg;
    end

    // trace stops after the source has been stored
    assign pb_wd_prev_src = last_src_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_src_reg <= 1'b0;
        end
        else if (cmd.trace_start)
        begin
            last_src_reg <= 1'b0;
        end
        else if (pb_we)
        begin
            last_src_reg <= (cur_reg == src_reg);
        end
    end

    // output register; path buffer read data is registered behind its address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid     <= 1'b0;
            emit_pend_reg <= 1'b0;
            emit_last_reg <= 1'b0;
        end
        else
        begin
            emit_pend_reg <= cmd.emit_step;
            emit_last_reg <= cmd.emit_step && stat.emit_done;
            if (cmd.out_load_fail || emit_pend_reg)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_fail)
        begin
            out_vertex <= '0;
            out_reach  <= 1'b0;
            out_hops   <= '0;
            out_last   <= 1'b1;
        end
        else if (emit_pend_reg)
        begin
            out_vertex <= pb_rd;
            out_reach  <= 1'b1;
            out_hops   <= hops_reg;
            out_last   <= emit_last_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bfs_shortest_path_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an edge beat is accepted with a row read, then the row is written in a write phase
// a search seeds the source, then pops each queued vertex, fetches its row and scans it,
// then traces the path from the target and emits one result per path vertex (or a fail result)
// one search at a time; no new beat is accepted until the search has emitted its results
// reset: asynchronous active low; afterwards a clearing pass over MAX_VERTICES
// rows (capped at 64) zeroes the adjacency memory while no beat is accepted
// ----------------------------------------------------------------------------
// bfs_shortest_path_core
// Breadth-first shortest path over a stored adjacency bit matrix.
// ----------------------------------------------------------------------------
module bfs_shortest_path_core
    import bfs_pkg::*;
#(
    parameter int MAX_VERTICES = VTX_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [6:0]   cfg_data,      // vertex_count
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [15:0]  s_axis_tdata,  // first_vertex[5:0], second_vertex[11:6], edge_present[12]
    input  wire         s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // path_vertex[5:0], reachable[6], hop_count[12:7]
    output logic        m_axis_tlast
);

    cmd_t  cmd;
    stat_t stat;
    logic  busy, wr_phase_reg, accept, start_search, wr_edge, out_free;
    logic [VTX_BITS-1:0] pv, hc;
    logic  rch;

    // edge beats use a read-modify-write with a separate write phase
    assign s_axis_tready = !busy && !wr_phase_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start_search  = accept && (s_axis_tuser == ACT_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_phase_reg <= 1'b0;
        end
        else
        begin
            wr_phase_reg <= accept && (s_axis_tuser == ACT_WRITE);
        end
    end

    // edge fields held for the write phase
    logic [VTX_BITS-1:0] ea_reg, eb_reg;
    logic eb_bit_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ea_reg     <= s_axis_tdata[5:0];
            eb_reg     <= s_axis_tdata[11:6];
            eb_bit_reg <= s_axis_tdata[12];
        end
    end
    assign wr_edge  = wr_phase_reg;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    bfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_search (start_search),
        .out_free     (out_free),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy)
    );

    bfs_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_edge      (wr_edge),
        .in_a         (wr_phase_reg ? ea_reg : s_axis_tdata[5:0]),
        .in_b         (wr_phase_reg ? eb_reg : s_axis_tdata[11:6]),
        .in_bit       (eb_bit_reg),
        .start_search (start_search),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_vertex   (pv),
        .out_reach    (rch),
        .out_hops     (hc),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, hc, rch, pv};

`ifndef SYNTHESIS
    // no input beat while the core is busy (clearing, searching or emitting)
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("beat accepted while busy");
    // a result only leaves with a consistent reach flag
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> m_axis_tlast)
        else $error("unreachable result not last");
    // write phase always follows an accepted edge beat
    a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_phase_reg |-> $past(s_axis_tvalid)) else $error("stray write phase");
`endif

endmodule
`default_nettype wire
